// File: sv/cdq_pkg.sv
// Package: deque depth, word type, action and status codes, channel structs.
package cdq_pkg;

  localparam int DEPTH = 16;
  localparam int WORD_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_PEEK       = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  localparam word_t EMPTY_WORD = -1;

  typedef struct packed {
    logic [2:0] action;
    word_t      item_value;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    word_t      popped_value;
    word_t      front_value;
    word_t      rear_value;
    logic       is_empty;
    logic       is_full;
  } out_t;

  typedef struct packed {
    logic  push_front;
    logic  push_back;
    logic  pop_front;
    logic  pop_back;
    word_t word;
  } cell_cmd_t;

endpackage

// File: sv/cdq_cell.sv
// One deque cell: holds a word and its valid bit, shifts with its neighbors.
module cdq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  cdq_pkg::cell_cmd_t cmd,
  input  cdq_pkg::word_t    left_data,
  input  logic              left_valid,
  input  cdq_pkg::word_t    right_data,
  input  logic              right_valid,
  output cdq_pkg::word_t    data_r,
  output logic              valid_r,
  output cdq_pkg::word_t    data_nxt,
  output logic              valid_nxt
);
  import cdq_pkg::*;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (cmd.push_front) begin
      data_nxt  = left_data;
      valid_nxt = left_valid;
    end else if (cmd.push_back) begin
      if (!valid_r && left_valid) begin
        data_nxt  = cmd.word;
        valid_nxt = 1'b1;
      end
    end else if (cmd.pop_front) begin
      data_nxt  = right_data;
      valid_nxt = right_valid;
    end else if (cmd.pop_back) begin
      if (valid_r && !right_valid) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

// File: sv/circular_deque_engine.sv
// Top level: deque engine built from a row of shifting cells.
// A request is taken every cycle unless a finished result waits on a stalled
// output; a result shows in the cycle after its request. The deque lives in
// a row of DEPTH cells kept packed from cell zero: pushes and pops at the front
// shift the whole row by one, those at the back touch only the cell at the
// rear edge. Front and rear words and the full and empty flags are read from
// the updated row in the same cycle. No clearing pass is needed after reset.
module circular_deque_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cdq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cdq_pkg::out_t out_data
);
  import cdq_pkg::*;

  word_t            cell_data   [DEPTH];
  word_t            cell_dnxt   [DEPTH];
  logic [DEPTH-1:0] cell_valid;
  logic [DEPTH-1:0] cell_vnxt;
  logic [DEPTH-1:0] last_cur;
  logic [DEPTH-1:0] last_nxt;
  cell_cmd_t        cmd;
  logic             accept;
  logic             full_cur;
  logic             empty_cur;
  logic             is_push;
  logic             is_pop;
  word_t            rear_cur;
  word_t            rear_nxt;
  out_t             res;
  logic             out_valid_r;
  out_t             out_data_r;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign full_cur  = cell_valid[DEPTH-1];
  assign empty_cur = !cell_valid[0];
  assign is_push   = (in_data.action == ACT_PUSH_FRONT) || (in_data.action == ACT_PUSH_BACK);
  assign is_pop    = (in_data.action == ACT_POP_FRONT) || (in_data.action == ACT_POP_BACK);

  always_comb begin
    cmd.push_front = accept && !full_cur && (in_data.action == ACT_PUSH_FRONT);
    cmd.push_back  = accept && !full_cur && (in_data.action == ACT_PUSH_BACK);
    cmd.pop_front  = accept && !empty_cur && (in_data.action == ACT_POP_FRONT);
    cmd.pop_back   = accept && !empty_cur && (in_data.action == ACT_POP_BACK);
    cmd.word       = in_data.item_value;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t left_d;
    logic  left_v;
    word_t right_d;
    logic  right_v;
    if (i == 0) begin : g_head
      assign left_d = in_data.item_value;
      assign left_v = 1'b1;
    end else begin : g_body
      assign left_d = cell_data[i-1];
      assign left_v = cell_valid[i-1];
    end
    if (i == DEPTH-1) begin : g_tail
      assign right_d = '0;
      assign right_v = 1'b0;
    end else begin : g_next
      assign right_d = cell_data[i+1];
      assign right_v = cell_valid[i+1];
    end
    cdq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .left_data   (left_d),
      .left_valid  (left_v),
      .right_data  (right_d),
      .right_valid (right_v),
      .data_r      (cell_data[i]),
      .valid_r     (cell_valid[i]),
      .data_nxt    (cell_dnxt[i]),
      .valid_nxt   (cell_vnxt[i])
    );
  end

  assign last_cur = cell_valid & ~{1'b0, cell_valid[DEPTH-1:1]};
  assign last_nxt = cell_vnxt & ~{1'b0, cell_vnxt[DEPTH-1:1]};

  always_comb begin
    rear_cur = '0;
    rear_nxt = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_cur = rear_cur | (last_cur[i] ? cell_data[i] : word_t'(0));
      rear_nxt = rear_nxt | (last_nxt[i] ? cell_dnxt[i] : word_t'(0));
    end
  end

  always_comb begin
    res.status       = ST_DONE;
    res.popped_value = '0;
    if (is_push && full_cur) begin
      res.status = ST_FULL;
    end else if (is_pop && empty_cur) begin
      res.status = ST_EMPTY;
    end else if (in_data.action == ACT_POP_FRONT) begin
      res.popped_value = cell_data[0];
    end else if (in_data.action == ACT_POP_BACK) begin
      res.popped_value = rear_cur;
    end
    res.is_empty    = !cell_vnxt[0];
    res.is_full     = cell_vnxt[DEPTH-1];
    res.front_value = cell_vnxt[0] ? cell_dnxt[0] : EMPTY_WORD;
    res.rear_value  = cell_vnxt[0] ? rear_nxt : EMPTY_WORD;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_packed_row: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_valid & (cell_valid + 1'b1)) == '0)
    else $error("cell row not packed from the head");

  a_flags_agree: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.is_full && out_data_r.is_empty))
    else $error("result flagged both full and empty");

  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_FULL) |-> out_data_r.is_full)
    else $error("push rejected while deque not full");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r && (out_data_r.is_empty == !cell_valid[0]))
    else $error("result missing or empty flag out of step with row");

endmodule
